/* src/fba_pkg.sv */
// ----------------------------------------------------------------------------
// fba_pkg: shared constants and codes of the fit block allocator
// Config register indices, policy codes, input modes and port widths.
// ----------------------------------------------------------------------------
package fba_pkg;

    localparam int unsigned CFG_INDEX_BITS = 1;
    localparam int unsigned CFG_DATA_BITS  = 7;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_FIT_POLICY  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BLOCK_COUNT = 1'b1;

    localparam logic [1:0] POL_BEST  = 2'd0;
    localparam logic [1:0] POL_FIRST = 2'd1;
    localparam logic [1:0] POL_NEXT  = 2'd2;
    localparam logic [1:0] POL_WORST = 2'd3;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_ALLOC = 1'b1;

    localparam int unsigned IN_INDEX_BITS  = 6;
    localparam int unsigned IN_AMOUNT_BITS = 16;
    localparam int unsigned COUNT_BITS     = 7;

endpackage

/* src/fit_block_allocator_core.sv */
// ----------------------------------------------------------------------------
// fit_block_allocator_core: free-size table with best/first/next/worst fit
// Block sizes live in a ring of cells that rotates one place a cycle while
// busy; a search watches cell 0 as every block passes and keeps the candidate.
// ----------------------------------------------------------------------------
//  channel   ports                                          direction
//  command   i_start, o_busy, i_mode, i_block_index, i_amount   in
//  result    o_valid, o_granted, o_block_number, o_remaining_size out
//  config    i_cfg_we, i_cfg_index, i_cfg_data                   in
//
//  A load completes with busy staying low. An allocate keeps busy high
//  through one full rotation of the ring to search, a second to bring the
//  chosen block to cell 0 for the subtraction and back to its place, and a
//  closing step; the result strobe follows in the next cycle.
//  Reset clears control and the next-fit pointer; block sizes are undefined
//  until loaded. The result strobe lasts one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
module fit_block_allocator_core #(
    parameter int unsigned NUM_BLOCKS = 64,
    parameter int unsigned SIZE_BITS  = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    output logic                                  o_busy,
    input  logic                                  i_mode,
    input  logic [fba_pkg::IN_INDEX_BITS-1:0]     i_block_index,
    input  logic [fba_pkg::IN_AMOUNT_BITS-1:0]    i_amount,
    input  logic                                  i_cfg_we,
    input  logic [fba_pkg::CFG_INDEX_BITS-1:0]    i_cfg_index,
    input  logic [fba_pkg::CFG_DATA_BITS-1:0]     i_cfg_data,
    output logic                                  o_valid,
    output logic                                  o_granted,
    output logic [fba_pkg::IN_INDEX_BITS-1:0]     o_block_number,
    output logic [fba_pkg::IN_AMOUNT_BITS-1:0]    o_remaining_size
);

    localparam int unsigned IB = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int unsigned CB = $clog2(2 * NUM_BLOCKS + 1) + 1;
    localparam int unsigned XB = (SIZE_BITS > fba_pkg::IN_AMOUNT_BITS) ?
                                 SIZE_BITS : fba_pkg::IN_AMOUNT_BITS;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIX, S_DONE} t_state;

    t_state                   r_state;
    logic [1:0]               r_policy;
    logic [fba_pkg::COUNT_BITS-1:0] r_count;
    logic [IB-1:0]            r_next;
    logic [CB-1:0]            r_step;
    logic [IB-1:0]            r_rot;    // index of the block now in cell 0
    logic [fba_pkg::IN_AMOUNT_BITS-1:0] r_req;
    logic                     r_found;
    logic                     r_wrap_found;
    logic [IB-1:0]            r_pick;
    logic [SIZE_BITS-1:0]     r_pick_size;
    logic [IB-1:0]            r_wrap_pick;
    logic                     r_valid;
    logic                     r_granted;
    logic [fba_pkg::IN_INDEX_BITS-1:0]  r_bnum;
    logic [fba_pkg::IN_AMOUNT_BITS-1:0] r_rem;

    logic [SIZE_BITS-1:0] w_size [NUM_BLOCKS];
    logic [SIZE_BITS-1:0] w_in   [NUM_BLOCKS];
    logic                 w_load [NUM_BLOCKS];
    logic                 w_shift;
    logic [IB:0]          w_cnt;
    logic                 w_active;
    logic                 w_fits;
    logic                 w_better;
    logic                 w_start;
    logic [SIZE_BITS-1:0] w_sub;
    logic                 w_ptr_ok;
    logic                 w_next_hit;

    assign w_start = i_start && (r_state == S_IDLE);
    assign w_cnt   = (32'(r_count) > NUM_BLOCKS) ?
                     (IB+1)'(NUM_BLOCKS) : (IB+1)'(r_count);
    assign w_active = ({1'b0, r_rot} < w_cnt);
    assign w_fits   = w_active && (XB'(w_size[0]) >= XB'(r_req));
    assign w_shift  = (r_state == S_SCAN) || (r_state == S_FIX);
    assign w_sub    = w_size[0] - SIZE_BITS'(r_req);
    // next fit starts at block 0 when the pointer is not below the count
    assign w_ptr_ok   = ({1'b0, r_next} < w_cnt);
    assign w_next_hit = w_fits && (!w_ptr_ok || (r_rot >= r_next)) && !r_found;

    always_comb begin
        w_better = 1'b0;
        case (r_policy)
            fba_pkg::POL_BEST:  w_better = !r_found || (w_size[0] < r_pick_size);
            fba_pkg::POL_WORST: w_better = !r_found || (w_size[0] > r_pick_size);
            fba_pkg::POL_FIRST: w_better = !r_found;
            fba_pkg::POL_NEXT:  w_better = !r_found;
            default:            w_better = 1'b0;
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < NUM_BLOCKS; g++) begin : g_cell
            assign w_load[g] = w_start && (i_mode == fba_pkg::MODE_LOAD) &&
                               (32'(i_block_index) == 32'(g)) && !w_shift;
            // cell 0 hands its block to the last cell; write the reduced size there
            assign w_in[g]   = (g == NUM_BLOCKS - 1 && r_state == S_FIX && r_found &&
                                r_rot == r_pick) ? w_sub : w_size[(g + 1) % NUM_BLOCKS];
            fba_cell #(.SIZE_BITS(SIZE_BITS)) u_cell (
                .i_clk      (i_clk),
                .i_shift    (w_shift),
                .i_load     (w_load[g]),
                .i_load_size(SIZE_BITS'(i_amount)),
                .i_prev_size(w_in[g]),
                .o_size     (w_size[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_policy  <= fba_pkg::POL_BEST;
            r_count   <= fba_pkg::COUNT_BITS'(1);
            r_next    <= '0;
            r_valid   <= 1'b0;
            r_found   <= 1'b0;
            r_wrap_found <= 1'b0;
            r_step    <= '0;
            r_rot     <= '0;
        end else begin
            r_valid <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    fba_pkg::CFG_FIT_POLICY:  r_policy <= i_cfg_data[1:0];
                    fba_pkg::CFG_BLOCK_COUNT: r_count  <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (w_start) begin
                        if (i_mode == fba_pkg::MODE_LOAD) begin
                            r_next <= '0;
                        end else begin
                            r_req        <= i_amount;
                            r_found      <= 1'b0;
                            r_wrap_found <= 1'b0;
                            r_step       <= '0;
                            r_rot        <= '0;
                            r_state      <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    // next fit: hits at or past the pointer win; else first hit wraps
                    if (w_fits) begin
                        if (r_policy == fba_pkg::POL_NEXT) begin
                            if (w_next_hit) begin
                                r_found <= 1'b1;
                                r_pick  <= r_rot;
                            end else if (!r_wrap_found) begin
                                r_wrap_found <= 1'b1;
                                r_wrap_pick  <= r_rot;
                            end
                        end else if (w_better) begin
                            r_found     <= 1'b1;
                            r_pick      <= r_rot;
                            r_pick_size <= w_size[0];
                        end
                    end
                    r_rot  <= (32'(r_rot) == NUM_BLOCKS - 1) ? '0 : r_rot + 1'b1;
                    r_step <= r_step + 1'b1;
                    if (32'(r_step) == NUM_BLOCKS - 1) begin
                        r_step <= '0;
                        if (!r_found && !w_next_hit && r_wrap_found) begin
                            r_found <= 1'b1;
                            r_pick  <= r_wrap_pick;
                        end
                        r_state <= S_FIX;
                    end
                end
                S_FIX: begin
                    if (r_found && r_rot == r_pick) begin
                        r_bnum <= fba_pkg::IN_INDEX_BITS'(r_pick);
                        r_rem  <= fba_pkg::IN_AMOUNT_BITS'(w_sub);
                        if (r_policy == fba_pkg::POL_NEXT) begin
                            r_next <= r_pick;
                        end
                    end
                    r_rot  <= (32'(r_rot) == NUM_BLOCKS - 1) ? '0 : r_rot + 1'b1;
                    r_step <= r_step + 1'b1;
                    if (32'(r_step) == NUM_BLOCKS - 1) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_valid   <= 1'b1;
                    r_granted <= r_found;
                    if (!r_found) begin
                        r_bnum <= '0;
                        r_rem  <= '0;
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy           = (r_state != S_IDLE);
    assign o_valid          = r_valid;
    assign o_granted        = r_granted;
    assign o_block_number   = r_bnum;
    assign o_remaining_size = r_rem;

endmodule

/* src/fba_cell.sv */
// ----------------------------------------------------------------------------
// fba_cell: one block entry of the allocator ring
// Holds one free size; a load sets it, else a shift step takes i_prev_size.
// ----------------------------------------------------------------------------
module fba_cell #(
    parameter int unsigned SIZE_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_shift,
    input  logic                 i_load,
    input  logic [SIZE_BITS-1:0] i_load_size,
    input  logic [SIZE_BITS-1:0] i_prev_size,
    output logic [SIZE_BITS-1:0] o_size
);

    logic [SIZE_BITS-1:0] r_size;
    logic [SIZE_BITS-1:0] n_size;

    always_comb begin
        n_size = r_size;
        if (i_load) begin
            n_size = i_load_size;
        end else if (i_shift) begin
            n_size = i_prev_size;
        end
    end

    always_ff @(posedge i_clk) begin
        r_size <= n_size;
    end

    assign o_size = r_size;

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking bench for fit_block_allocator_core
// Loads block sizes and issues allocate requests under every fit policy
// and several block counts, predicts each grant in the bench and compares
// every result strobe with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

    localparam int NBLK        = 64;
    localparam int QUIET_WAIT  = 2 * NBLK + 60;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic        is_cfg;
        logic        mode;
        logic [5:0]  idx;
        logic [15:0] amount;
    } t_plan;

    typedef struct packed {
        logic        granted;
        logic [5:0]  number;
        logic [15:0] remaining;
    } t_grant;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic        i_mode;
    logic [5:0]  i_block_index;
    logic [15:0] i_amount;
    logic        i_cfg_we;
    logic [fba_pkg::CFG_INDEX_BITS-1:0] i_cfg_index;
    logic [fba_pkg::CFG_DATA_BITS-1:0]  i_cfg_data;
    logic        o_valid;
    logic        o_granted;
    logic [5:0]  o_block_number;
    logic [15:0] o_remaining_size;

    fit_block_allocator_core DUT (.*);

    // bench copy of the allocator state
    logic [15:0] free_size [NBLK];
    logic [5:0]  next_ptr;
    logic [1:0]  policy;
    logic [6:0]  blk_count;

    t_plan  pending_q[$];
    t_grant grant_q[$];

    logic took;
    int   quiet, cycles, errors;
    int   burst_left, gap_left;
    int   n_alloc, n_grant, n_load, n_cfg;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic predict_transfer(input logic mode, input logic [5:0] idx,
                                    input logic [15:0] amt);
        int     cnt, pick, pos;
        t_grant g;
        if (mode == fba_pkg::MODE_LOAD) begin
            free_size[idx] = amt;
            next_ptr = '0;
            n_load++;
            return;
        end
        cnt  = (blk_count > NBLK) ? NBLK : blk_count;
        pick = -1;
        if (policy == fba_pkg::POL_NEXT) begin
            pos = (next_ptr < cnt) ? next_ptr : 0;
            for (int i = 0; i < cnt; i++) begin
                if (free_size[pos] >= amt) begin
                    pick = pos;
                    break;
                end
                pos = (pos + 1 == cnt) ? 0 : pos + 1;
            end
            if (pick >= 0) next_ptr = pick[5:0];
        end else begin
            for (int i = 0; i < cnt; i++) begin
                if (free_size[i] < amt) continue;
                if (pick < 0) pick = i;
                else if (policy == fba_pkg::POL_BEST && free_size[i] < free_size[pick])
                    pick = i;
                else if (policy == fba_pkg::POL_WORST && free_size[i] > free_size[pick])
                    pick = i;
                if (policy == fba_pkg::POL_FIRST) break;
            end
        end
        g = '0;
        if (pick >= 0) begin
            free_size[pick] = free_size[pick] - amt;
            g.granted   = 1'b1;
            g.number    = pick[5:0];
            g.remaining = free_size[pick];
            n_grant++;
        end
        n_alloc++;
        grant_q.push_back(g);
    endtask

    task automatic add_item(input logic mode, input logic [5:0] idx, input logic [15:0] amt);
        t_plan p;
        p = '{is_cfg: 1'b0, mode: mode, idx: idx, amount: amt};
        pending_q.push_back(p);
    endtask

    task automatic add_cfg(input logic [fba_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [6:0] val);
        t_plan p;
        p = '{is_cfg: 1'b1, mode: 1'b0, idx: {5'd0, idx}, amount: {9'd0, val}};
        pending_q.push_back(p);
    endtask

    function automatic logic [15:0] rand_size();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(0, 3000));
        endcase
    endfunction

    // monitor: predict on command transfers, check result strobes
    always @(posedge i_clk) begin
        t_grant exp_g;
        if (!i_rst_n) begin
            took  <= 1'b0;
            quiet <= 0;
        end else begin
            if (o_valid) begin
                if (grant_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result: granted=%0d block=%0d rem=%0d",
                                 o_granted, o_block_number, o_remaining_size);
                end else begin
                    exp_g = grant_q.pop_front();
                    if (o_granted !== exp_g.granted || o_block_number !== exp_g.number ||
                        o_remaining_size !== exp_g.remaining) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: exp g=%0d b=%0d r=%0d got g=%0d b=%0d r=%0d",
                                     exp_g.granted, exp_g.number, exp_g.remaining,
                                     o_granted, o_block_number, o_remaining_size);
                    end
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_index == fba_pkg::CFG_FIT_POLICY) policy = i_cfg_data[1:0];
                else blk_count = i_cfg_data;
                n_cfg++;
            end
            if (i_start && !o_busy)
                predict_transfer(i_mode, i_block_index, i_amount);
            took  <= i_start && !o_busy;
            quiet <= (o_valid || (i_start && !o_busy) || o_busy) ? 0 : quiet + 1;
        end
    end

    // driver: bursts of commands with random gaps; config only when idle
    always @(negedge i_clk) begin
        logic  nxt_start;
        t_plan p;
        if (i_rst_n) begin
            nxt_start = took ? 1'b0 : i_start;
            i_cfg_we <= 1'b0;
            if (!nxt_start) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_q.size() > 0) begin
                    if (pending_q[0].is_cfg) begin
                        if (grant_q.size() == 0 && quiet >= QUIET_WAIT) begin
                            p = pending_q.pop_front();
                            i_cfg_we    <= 1'b1;
                            i_cfg_index <= p.idx[fba_pkg::CFG_INDEX_BITS-1:0];
                            i_cfg_data  <= p.amount[6:0];
                        end
                    end else begin
                        p = pending_q.pop_front();
                        i_mode        <= p.mode;
                        i_block_index <= p.idx;
                        i_amount      <= p.amount;
                        nxt_start = 1'b1;
                        if (burst_left > 0) begin
                            burst_left--;
                        end else begin
                            burst_left = $urandom_range(0, 20);
                            gap_left   = ($urandom_range(0, 7) == 0) ?
                                         $urandom_range(50, 150) : $urandom_range(0, 6);
                        end
                    end
                end
            end
            i_start <= nxt_start;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        logic [6:0] cnt_pick;
        logic [1:0] pol;
        int         n_items;
        i_rst_n = 1'b0; i_start = 1'b0; i_mode = fba_pkg::MODE_LOAD; i_block_index = '0;
        i_amount = '0; i_cfg_we = 1'b0; i_cfg_index = fba_pkg::CFG_FIT_POLICY;
        i_cfg_data = '0;
        policy = fba_pkg::POL_BEST; blk_count = 7'd1; next_ptr = '0;
        cycles = 0; errors = 0; burst_left = 0; gap_left = 0;
        n_alloc = 0; n_grant = 0; n_load = 0; n_cfg = 0;

        // fill every block so no search ever reads an unloaded entry
        add_cfg(fba_pkg::CFG_BLOCK_COUNT, 7'd64);
        for (int b = 0; b < NBLK; b++)
            add_item(fba_pkg::MODE_LOAD, 6'(b),
                     (b == 0) ? 16'h0000 : (b == 63) ? 16'hFFFF : rand_size());

        // directed: zero request, full-size (FFFF) request, mid request and a second FFFF request per policy
        for (int p = 0; p < 4; p++) begin
            add_cfg(fba_pkg::CFG_FIT_POLICY, 7'(p));
            add_item(fba_pkg::MODE_ALLOC, 6'h3F, 16'h0000);
            add_item(fba_pkg::MODE_ALLOC, 6'h00, 16'hFFFF);
            add_item(fba_pkg::MODE_ALLOC, 6'h2A, 16'd700);
            add_item(fba_pkg::MODE_ALLOC, 6'h15, 16'hFFFF);
        end
        // count zero fails everything; count past the table acts as full
        add_cfg(fba_pkg::CFG_BLOCK_COUNT, 7'd0);
        add_item(fba_pkg::MODE_ALLOC, 6'd0, 16'd0);
        add_cfg(fba_pkg::CFG_BLOCK_COUNT, 7'd127);
        add_item(fba_pkg::MODE_ALLOC, 6'd0, 16'd1);
        // next fit with the pointer left beyond a reduced count
        add_cfg(fba_pkg::CFG_FIT_POLICY, {5'd0, fba_pkg::POL_NEXT});
        add_item(fba_pkg::MODE_LOAD, 6'd50, 16'd9000);
        add_item(fba_pkg::MODE_ALLOC, 6'd0, 16'd8500);
        add_cfg(fba_pkg::CFG_BLOCK_COUNT, 7'd10);
        add_item(fba_pkg::MODE_ALLOC, 6'd0, 16'd0);

        // random phases, each with its own policy and count
        n_items = 0;
        while (n_items < 1300) begin
            pol = 2'($urandom_range(0, 3));
            case ($urandom_range(0, 5))
                0:       cnt_pick = 7'd1;
                1:       cnt_pick = 7'd64;
                2:       cnt_pick = 7'($urandom_range(65, 127));
                3:       cnt_pick = ($urandom_range(0, 3) == 0) ? 7'd0 : 7'd2;
                default: cnt_pick = 7'($urandom_range(1, 64));
            endcase
            add_cfg(fba_pkg::CFG_FIT_POLICY, {5'd0, pol});
            add_cfg(fba_pkg::CFG_BLOCK_COUNT, cnt_pick);
            for (int k = $urandom_range(40, 120); k > 0; k--) begin
                if ($urandom_range(0, 9) < 3)
                    add_item(fba_pkg::MODE_LOAD, 6'($urandom_range(0, 63)), rand_size());
                else
                    add_item(fba_pkg::MODE_ALLOC, 6'($urandom_range(0, 63)),
                             ($urandom_range(0, 9) == 0) ? rand_size()
                                                         : 16'($urandom_range(0, 1500)));
                n_items++;
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_q.size() == 0 && !i_start && grant_q.size() == 0);
        repeat (QUIET_WAIT) @(posedge i_clk);
        $display("covered %0d loads, %0d allocates (%0d granted), %0d register writes",
                 n_load, n_alloc, n_grant, n_cfg);
        $display("mismatches: %0d, results still pending: %0d", errors, grant_q.size());
        if (errors == 0 && grant_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
